/* design/dmac_pkg.sv */
package dmac_pkg;

    localparam int unsigned MaxChannels = 8;
    localparam logic [7:0] OffStatus = 8'h00;
    localparam logic [7:0] OffFlagClear = 8'h04;
    localparam logic [7:0] ChBase = 8'h08;
    localparam logic [7:0] ChStride = 8'h14;

    // word index inside one channel's register block
    localparam logic [2:0] WordCtl = 3'd0;
    localparam logic [2:0] WordCount = 3'd1;
    localparam logic [2:0] WordPeriph = 3'd2;
    localparam logic [2:0] WordMem = 3'd3;
    localparam logic [2:0] WordSpare = 3'd4;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_REQUEST = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CALC,
        ST_DONE
    } t_state;

    // command from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic calc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_request;
    } t_status;

    function automatic logic [2:0] width_of(input logic [1:0] sel);
        unique case (sel)
            2'd0:    width_of = 3'd1;
            2'd1:    width_of = 3'd2;
            default: width_of = 3'd4;
        endcase
    endfunction

endpackage

/* design/dma_channel_controller.sv */
// dma channel controller: register file for up to CHANNELS channels plus a
// transfer engine. one word is taken at a time; a register write or read
// runs through the exec state, a transfer request through the exec and
// calc states (decode and state update, then the address scale multiply).
// the result word is registered and shown in the done state, held until
// taken, and the next word is taken in the cycle after that.
module dma_channel_controller #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_channel,
    input  logic        i_bus_ok,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_accepted,
    output logic        o_transfer_made,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [2:0]  o_source_size,
    output logic [2:0]  o_destination_size,
    output logic        o_to_peripheral,
    output logic        o_transfer_complete,
    output logic        o_transfer_error,
    output logic        o_interrupt
);
    import dmac_pkg::*;

    t_cmd    cmd;
    t_status status;

    dmac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dmac_dpath #(.CHANNELS(CHANNELS)) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_mode                (i_mode),
        .i_reg_offset          (i_reg_offset),
        .i_write_data          (i_write_data),
        .i_channel             (i_channel),
        .i_bus_ok              (i_bus_ok),
        .o_read_data           (o_read_data),
        .o_accepted            (o_accepted),
        .o_transfer_made       (o_transfer_made),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_source_size         (o_source_size),
        .o_destination_size    (o_destination_size),
        .o_to_peripheral       (o_to_peripheral),
        .o_transfer_complete   (o_transfer_complete),
        .o_transfer_error      (o_transfer_error),
        .o_interrupt           (o_interrupt)
    );

    // never ready and valid together in this one-word-at-a-time sequence
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid overlap");

    // a transfer always reports acceptance
    a_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_transfer_made |-> o_accepted) else $error("transfer not accepted");

    // completion and error exclude each other
    a_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_transfer_complete && o_transfer_error))
        else $error("complete with error");
endmodule

/* design/dmac_ctrl.sv */
module dmac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  dmac_pkg::t_status i_status,
    output dmac_pkg::t_cmd    o_cmd
);
    import dmac_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = i_status.is_request ? ST_CALC : ST_DONE;
            ST_CALC: n_state = ST_DONE;
            ST_DONE: if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_DONE);
        o_cmd.capture = (r_state == ST_IDLE) && i_valid;
        o_cmd.execute = (r_state == ST_EXEC);
        o_cmd.calc = (r_state == ST_CALC);
        o_cmd.out_load = ((r_state == ST_EXEC) && !i_status.is_request) || (r_state == ST_CALC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* design/dmac_dpath.sv */
module dmac_dpath #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmac_pkg::t_cmd    i_cmd,
    output dmac_pkg::t_status o_status,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_reg_offset,
    input  logic [31:0]       i_write_data,
    input  logic [3:0]        i_channel,
    input  logic              i_bus_ok,
    output logic [31:0]       o_read_data,
    output logic              o_accepted,
    output logic              o_transfer_made,
    output logic [31:0]       o_source_address,
    output logic [31:0]       o_destination_address,
    output logic [2:0]        o_source_size,
    output logic [2:0]        o_destination_size,
    output logic              o_to_peripheral,
    output logic              o_transfer_complete,
    output logic              o_transfer_error,
    output logic              o_interrupt
);
    import dmac_pkg::*;

    localparam int unsigned ChW = 3;

    logic [31:0] r_status;
    logic [31:0] r_ctl [MaxChannels];
    logic [31:0] r_cnt [MaxChannels];
    logic [31:0] r_pa [MaxChannels];
    logic [31:0] r_ma [MaxChannels];
    logic [31:0] r_spare [MaxChannels];
    logic [15:0] r_reload [MaxChannels];

    logic [1:0]  r_mode;
    logic [7:0]  r_off;
    logic [31:0] r_data;
    logic [3:0]  r_chan;
    logic        r_bus_ok;

    // intermediate transfer values, registered between exec and calc
    logic        r_xfer;
    logic [31:0] r_moved, r_pa_t, r_ma_t;
    logic [2:0]  r_pw, r_mw;
    logic        r_pinc, r_minc, r_m2p, r_cpl, r_irq;

    // register decode
    logic [7:0]     rel;
    logic [2:0]     dec_w;
    logic           dec_hit;
    logic [ChW-1:0] ci;

    always_comb begin
        rel = r_off - ChBase;
        ci = '0;
        dec_w = WordCtl;
        for (int k = 0; k < MaxChannels; k++) begin
            if (rel >= 8'(k * 20) && rel < 8'((k + 1) * 20)) begin
                ci = ChW'(k);
                dec_w = 3'((rel - 8'(k * 20)) >> 2);
            end
        end
        dec_hit = (r_off >= ChBase) && (rel < 8'(CHANNELS * 20));
    end

    logic [31:0] rd_word;
    always_comb begin
        unique case (dec_w)
            WordCtl:    rd_word = r_ctl[ci];
            WordCount:  rd_word = r_cnt[ci];
            WordPeriph: rd_word = r_pa[ci];
            WordMem:    rd_word = r_ma[ci];
            default:    rd_word = r_spare[ci];
        endcase
    end

    logic [31:0] read_val;
    always_comb begin
        read_val = '0;
        if (t_mode'(r_mode) == MODE_READ) begin
            if (r_off == OffStatus) read_val = r_status;
            else if (r_off != OffFlagClear && dec_hit) read_val = rd_word;
        end
    end

    // request checks
    logic [ChW-1:0] rc;
    logic           ch_ok, req_ok;
    logic [31:0]    ctl;
    logic [15:0]    rem;
    always_comb begin
        rc = ChW'(r_chan - 4'd1);
        ctl = r_ctl[rc];
        rem = r_cnt[rc][15:0];
        ch_ok = (r_chan != 4'd0) && ({28'd0, r_chan} <= 32'(CHANNELS));
        req_ok = ch_ok && ctl[0] && (rem != 16'd0);
    end

    logic [15:0] nrem;
    logic        cpl;
    logic        xfer_go;
    assign nrem = r_bus_ok ? rem - 16'd1 : rem;
    assign cpl = r_bus_ok && (nrem == 16'd0);
    assign xfer_go = req_ok && (r_reload[rc] != 16'd0);

    assign o_status.is_request = (t_mode'(r_mode) == MODE_REQUEST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_off <= {i_reg_offset[7:2], 2'b00};
            r_data <= i_write_data;
            r_chan <= i_channel;
            r_bus_ok <= i_bus_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            for (int k = 0; k < MaxChannels; k++) begin
                r_ctl[k] <= '0;
                r_cnt[k] <= '0;
                r_pa[k] <= '0;
                r_ma[k] <= '0;
                r_spare[k] <= '0;
                r_reload[k] <= '0;
            end
            r_xfer <= 1'b0;
        end else if (i_cmd.execute) begin
            r_xfer <= o_status.is_request && xfer_go;
            unique case (t_mode'(r_mode))
                MODE_WRITE: begin
                    if (r_off == OffFlagClear) begin
                        r_status <= r_status & ~r_data;
                    end else if (r_off != OffStatus && dec_hit) begin
                        unique case (dec_w)
                            WordCtl: begin
                                r_ctl[ci] <= r_data;
                                if (!r_ctl[ci][0] && r_data[0])
                                    r_reload[ci] <= r_cnt[ci][15:0];
                            end
                            WordCount:  r_cnt[ci] <= r_data;
                            WordPeriph: r_pa[ci] <= r_data;
                            WordMem:    r_ma[ci] <= r_data;
                            default:    r_spare[ci] <= r_data;
                        endcase
                    end
                end
                MODE_REQUEST: begin
                    if (xfer_go) begin
                        if (cpl && ctl[5]) r_cnt[rc] <= {16'd0, r_reload[rc]};
                        else r_cnt[rc] <= {16'd0, nrem};
                        if (cpl) begin
                            r_status[{rc, 2'b00}] <= 1'b1;
                            r_status[{rc, 2'b01}] <= 1'b1;
                            if (!ctl[5]) r_ctl[rc][0] <= 1'b0;
                        end else if (!r_bus_ok) begin
                            r_status[{rc, 2'b00}] <= 1'b1;
                            r_status[{rc, 2'b11}] <= 1'b1;
                            r_ctl[rc][0] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // capture transfer operands for the multiply stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_moved <= {16'd0, r_reload[rc]} - {16'd0, rem};
            r_pa_t <= r_pa[rc];
            r_ma_t <= r_ma[rc];
            r_pw <= width_of(ctl[9:8]);
            r_mw <= width_of(ctl[11:10]);
            r_pinc <= ctl[6];
            r_minc <= ctl[7];
            r_m2p <= ctl[4];
            r_cpl <= cpl;
            r_irq <= cpl ? ctl[1] : (!r_bus_ok && ctl[3]);
        end
    end

    // acceptance flag as seen before execute changed the channel state
    logic r_req_ok;
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) r_req_ok <= req_ok;
    end

    logic [31:0] pa_n, ma_n;
    assign pa_n = r_pinc ? r_pa_t + 32'(r_moved * {29'd0, r_pw}) : r_pa_t;
    assign ma_n = r_minc ? r_ma_t + 32'(r_moved * {29'd0, r_mw}) : r_ma_t;

    // transfer fields are shown only for a request that made a transfer
    logic xfer_out;
    assign xfer_out = i_cmd.calc && r_xfer;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_read_data <= read_val;
            o_accepted <= i_cmd.calc && r_req_ok;
            o_transfer_made <= xfer_out;
            o_source_address <= xfer_out ? (r_m2p ? ma_n : pa_n) : '0;
            o_destination_address <= xfer_out ? (r_m2p ? pa_n : ma_n) : '0;
            o_source_size <= xfer_out ? (r_m2p ? r_mw : r_pw) : '0;
            o_destination_size <= xfer_out ? (r_m2p ? r_pw : r_mw) : '0;
            o_to_peripheral <= xfer_out && r_m2p;
            o_transfer_complete <= xfer_out && r_cpl;
            o_transfer_error <= xfer_out && !r_bus_ok;
            o_interrupt <= xfer_out && r_irq;
        end
    end
endmodule
